### rtl/buddy_block_allocator_macros.svh
// Assertion macros for the buddy block allocator.
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define BBA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked out of reset.
`define BBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BBA_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define BBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### rtl/bba_pkg.sv
package bba_pkg;

  localparam int MAX_LEVELS_DEF = 16;
  localparam int CFG_W = 5;
  localparam int SHIFT_CAP = 20;
  localparam logic [CFG_W-1:0] SHIFT_RESET = 5'd4;
  localparam logic [CFG_W-1:0] LEVELS_RESET = 5'd16;

  // Configuration register indexes.
  localparam logic [3:0] REG_MIN_SHIFT = 4'd0;
  localparam logic [3:0] REG_LEVELS = 4'd1;

  // Node states.
  localparam logic [1:0] NODE_FREE = 2'd0;
  localparam logic [1:0] NODE_SPLIT = 2'd1;
  localparam logic [1:0] NODE_USED = 2'd2;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_SPACE = 2'd1,
    STAT_BAD_SIZE = 2'd2,
    STAT_BAD_ADDR = 2'd3
  } status_t;

  typedef struct packed {
    logic        opcode;
    logic [35:0] request_size;
    logic [35:0] free_offset;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [34:0] block_offset;
    logic [3:0]  block_order;
    logic [35:0] used_bytes;
    logic [31:0] alloc_count;
    logic [31:0] free_count;
    logic [31:0] fail_count;
    logic [31:0] split_count;
    logic [31:0] merge_count;
  } result_t;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_KSTEP,
    OP_ROOT,
    OP_DESCEND,
    OP_SPLIT,
    OP_TAKE,
    OP_RIGHT,
    OP_UP,
    OP_LEAF,
    OP_FIN_FREE,
    OP_WR_FREE,
    OP_BUDDY_RD,
    OP_MERGE,
    OP_FAIL,
    OP_FIN_ERR,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic       is_free;
    logic       size_zero;
    logic       k_done;
    logic       k_ovf;
    logic       range_bad;
    logic [1:0] rd_state;
    logic       ord_lt;
    logic       ord_zero;
    logic       ord_eq;
    logic       at_root;
    logic       right_ok;
    logic       clr_last;
  } dp_stat_t;

endpackage

### rtl/buddy_block_allocator.sv
// Channel   Signals                                   Transfer
// request   start, busy, req                          start high while busy low
// result    done, result                              done high, one cycle, no stall
// config    cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid and cfg_ready high
//
// After reset a clearing pass marks every node free; busy is high during it.
// An allocate first raises the size order k, then walks the tree from the root,
// reading each node and descending, splitting or stepping back up; a free walks
// up from the leaf to the used node, then merges while the buddy is free. Both
// walks read the node memory one node at a time with a registered read.
// Results cannot be stalled; busy drops on the result cycle.
`include "buddy_block_allocator_macros.svh"
module buddy_block_allocator import bba_pkg::*; #(
  parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        req,
  output logic        done,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  bba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  bba_datapath #(.MAX_LEVELS(MAX_LEVELS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .done      (done),
    .result    (result)
  );

  `BBA_ASSERT_NOW(a_done_idle, clk, rst, done, !busy, "result shown while busy")
  `BBA_ASSERT_NEXT(a_done_single, clk, rst, done, !done, "result strobe repeated")
  `BBA_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy && !done, "request not taken")

endmodule

### rtl/bba_ctrl.sv
module bba_ctrl import bba_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_KSTEP, S_A_RD, S_A_EV, S_A_BACK,
    S_F_RD, S_F_EV, S_F_WR, S_F_BRD, S_F_BEV, S_EMIT
  } state_t;

  state_t state, state_next;

  assign busy = (state != S_IDLE);

  // Sequencing of the clearing pass, request dispatch, and the search and merge walks.
  always_comb begin
    state_next = state;
    cmd = '{op: OP_NONE, code: STAT_OK};
    case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.op = OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.is_free) begin
          if (stat.range_bad) begin
            cmd = '{op: OP_FIN_ERR, code: STAT_BAD_ADDR};
            state_next = S_EMIT;
          end else begin
            cmd.op = OP_LEAF;
            state_next = S_F_RD;
          end
        end else if (stat.size_zero) begin
          cmd = '{op: OP_FIN_ERR, code: STAT_BAD_SIZE};
          state_next = S_EMIT;
        end else begin
          state_next = S_KSTEP;
        end
      end
      S_KSTEP: begin
        if (!stat.k_done) begin
          cmd.op = OP_KSTEP;
        end else if (stat.k_ovf) begin
          cmd.op = OP_FAIL;
          state_next = S_EMIT;
        end else begin
          cmd.op = OP_ROOT;
          state_next = S_A_RD;
        end
      end
      S_A_RD: state_next = S_A_EV;
      S_A_EV: begin
        if (stat.ord_lt || stat.rd_state == NODE_USED ||
            (stat.rd_state == NODE_SPLIT && stat.ord_zero)) begin
          state_next = S_A_BACK;
        end else if (stat.rd_state == NODE_SPLIT) begin
          cmd.op = OP_DESCEND;
          state_next = S_A_RD;
        end else if (stat.ord_eq) begin
          cmd.op = OP_TAKE;
          state_next = S_EMIT;
        end else begin
          cmd.op = OP_SPLIT;
          state_next = S_A_RD;
        end
      end
      S_A_BACK: begin
        if (stat.at_root) begin
          cmd.op = OP_FAIL;
          state_next = S_EMIT;
        end else if (stat.right_ok) begin
          cmd.op = OP_RIGHT;
          state_next = S_A_RD;
        end else begin
          cmd.op = OP_UP;
        end
      end
      S_F_RD: state_next = S_F_EV;
      S_F_EV: begin
        if (stat.rd_state == NODE_USED) begin
          cmd.op = OP_FIN_FREE;
          state_next = S_F_WR;
        end else if (stat.at_root) begin
          cmd = '{op: OP_FIN_ERR, code: STAT_BAD_ADDR};
          state_next = S_EMIT;
        end else begin
          cmd.op = OP_UP;
          state_next = S_F_RD;
        end
      end
      S_F_WR: begin
        cmd.op = OP_WR_FREE;
        state_next = stat.at_root ? S_EMIT : S_F_BRD;
      end
      S_F_BRD: begin
        cmd.op = OP_BUDDY_RD;
        state_next = S_F_BEV;
      end
      S_F_BEV: begin
        if (stat.rd_state == NODE_FREE) begin
          cmd.op = OP_MERGE;
          state_next = S_F_WR;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.op = OP_EMIT;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

endmodule

### rtl/bba_datapath.sv
module bba_datapath import bba_pkg::*; #(
  parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  input  logic [3:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  req_t       req,
  input  dp_cmd_t    cmd,
  output dp_stat_t   stat,
  output logic       done,
  output result_t    result
);

  localparam int NW = MAX_LEVELS;
  localparam int DEPTH = (1 << MAX_LEVELS) - 1;
  localparam int DW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam logic [NW-1:0] LAST_NODE = NW'(DEPTH - 1);

  logic [CFG_W-1:0] min_block_shift, levels_in_use;
  logic [CFG_W-1:0] sh, lv, k, order_w;
  req_t             cur;
  logic [NW-1:0]    node, raddr;
  logic [DW-1:0]    d;
  logic [MAX_LEVELS-1:0] mark;
  logic [1:0]       mem [0:DEPTH-1];
  logic [1:0]       rdata, wdata;
  logic             we;
  status_t          res_status;
  logic [34:0]      res_offset;
  logic [3:0]       res_order;
  logic [35:0]      used_total;
  logic [31:0]      alloc_total, free_total, fail_total, split_total, merge_total;
  logic [63:0]      blk, rel, off, total, leaf;
  logic [5:0]       dk;

  // Configuration registers, taken at any write transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_block_shift <= SHIFT_RESET;
      levels_in_use <= LEVELS_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_MIN_SHIFT) min_block_shift <= cfg_data[CFG_W-1:0];
      else if (cfg_index == REG_LEVELS) levels_in_use <= cfg_data[CFG_W-1:0];
    end
  end

  // Effective register values and derived quantities.
  always_comb begin
    sh = (min_block_shift > CFG_W'(SHIFT_CAP)) ? CFG_W'(SHIFT_CAP) : min_block_shift;
    if (levels_in_use == '0) lv = CFG_W'(1);
    else if (levels_in_use > CFG_W'(MAX_LEVELS)) lv = CFG_W'(MAX_LEVELS);
    else lv = levels_in_use;
    order_w = lv - CFG_W'(1) - CFG_W'(d);
    blk = 64'(1) << (6'(sh) + 6'(order_w));
    rel = 64'(node) + 64'(1) - (64'(1) << d);
    off = rel << (6'(sh) + 6'(order_w));
    total = 64'(1) << (6'(sh) + 6'(lv) - 6'(1));
    leaf = (64'(1) << (lv - CFG_W'(1))) - 64'(1) + (64'(cur.free_offset) >> sh);
    dk = 6'(d) + 6'(k);
  end

  // Status to the controller.
  always_comb begin
    stat.is_free   = cur.opcode;
    stat.size_zero = (cur.request_size == '0);
    stat.k_ovf     = (k >= lv);
    stat.k_done    = (k >= lv) ||
                     !((64'(1) << (6'(sh) + 6'(k))) < 64'(cur.request_size));
    stat.range_bad = (64'(cur.free_offset) >= total) ||
                     ((cur.free_offset & ((36'(1) << sh) - 36'(1))) != '0);
    stat.rd_state  = rdata;
    stat.ord_lt    = (dk >= 6'(lv));
    stat.ord_eq    = (dk == 6'(lv) - 6'(1));
    stat.ord_zero  = (6'(d) == 6'(lv) - 6'(1));
    stat.at_root   = (node == '0);
    stat.right_ok  = node[0] && mark[d - DW'(1)];
    stat.clr_last  = (node == LAST_NODE);
  end

  // Node memory: one write and one registered read per cycle.
  always_comb begin
    raddr = node;
    if (cmd.op == OP_BUDDY_RD) raddr = node[0] ? node + NW'(1) : node - NW'(1);
    we = 1'b0;
    wdata = NODE_FREE;
    case (cmd.op)
      OP_CLEAR, OP_WR_FREE: we = 1'b1;
      OP_SPLIT: begin
        we = 1'b1;
        wdata = NODE_SPLIT;
      end
      OP_TAKE: begin
        we = 1'b1;
        wdata = NODE_USED;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[node] <= wdata;
    rdata <= mem[raddr];
  end

  // Walk pointer, depth and search marks.
  always_ff @(posedge clk) begin
    if (rst) begin
      node <= '0;
      d <= '0;
    end else begin
      case (cmd.op)
        OP_CLEAR: node <= node + NW'(1);
        OP_ROOT: begin
          node <= '0;
          d <= '0;
        end
        OP_DESCEND, OP_SPLIT: begin
          mark[d] <= (cmd.op == OP_DESCEND);
          node <= NW'((node << 1) | NW'(1));
          d <= d + DW'(1);
        end
        OP_RIGHT: node <= node + NW'(1);
        OP_UP, OP_MERGE: begin
          node <= (node - NW'(1)) >> 1;
          d <= d - DW'(1);
        end
        OP_LEAF: begin
          node <= leaf[NW-1:0];
          d <= DW'(lv - CFG_W'(1));
        end
        default: node <= node;
      endcase
    end
  end

  // Request latch, size order search and per-request result fields.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        cur <= req;
        k <= '0;
        res_status <= STAT_OK;
        res_offset <= '0;
        res_order <= '0;
      end
      OP_KSTEP: k <= k + CFG_W'(1);
      OP_TAKE, OP_FIN_FREE: begin
        res_offset <= off[34:0];
        res_order <= order_w[3:0];
      end
      OP_FAIL: res_status <= STAT_NO_SPACE;
      OP_FIN_ERR: res_status <= cmd.code;
      default: k <= k;
    endcase
  end

  // Statistics counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      used_total <= '0;
      alloc_total <= '0;
      free_total <= '0;
      fail_total <= '0;
      split_total <= '0;
      merge_total <= '0;
    end else begin
      case (cmd.op)
        OP_SPLIT: split_total <= split_total + 32'd1;
        OP_TAKE: begin
          alloc_total <= alloc_total + 32'd1;
          used_total <= used_total + blk[35:0];
        end
        OP_FIN_FREE: begin
          free_total <= free_total + 32'd1;
          used_total <= used_total - blk[35:0];
        end
        OP_MERGE: merge_total <= merge_total + 32'd1;
        OP_FAIL: fail_total <= fail_total + 32'd1;
        default: used_total <= used_total;
      endcase
    end
  end

  // Result register and its one-cycle strobe.
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= (cmd.op == OP_EMIT);
    if (cmd.op == OP_EMIT) begin
      result.status <= res_status;
      result.block_offset <= res_offset;
      result.block_order <= res_order;
      result.used_bytes <= used_total;
      result.alloc_count <= alloc_total;
      result.free_count <= free_total;
      result.fail_count <= fail_total;
      result.split_count <= split_total;
      result.merge_count <= merge_total;
    end
  end

endmodule

### bench/bba_result_checker.sv
`timescale 1ns / 1ps
// Watches the request, configuration and result channels of the allocator,
// keeps its own copy of the node tree and counters, and compares every result.
module bba_result_checker import bba_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  req_t        req,
  input  logic        done,
  input  result_t     result,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          checked
);

  localparam int TREE_NODES = 65535;
  localparam logic [63:0] MASK36 = 64'hF_FFFF_FFFF;
  localparam logic [63:0] MASK35 = 64'h7_FFFF_FFFF;

  logic [1:0]  tree_st [0:TREE_NODES-1];
  logic [4:0]  shift_reg;
  logic [4:0]  levels_reg;
  logic [35:0] used_sum;
  logic [31:0] n_alloc, n_free, n_fail, n_split, n_merge;
  int unsigned claimed_node;
  result_t     outcome_q [$];

  assign pending = outcome_q.size();

  function automatic int unsigned level_of(int unsigned node);
    return $clog2(node + 2) - 1;
  endfunction

  // Depth-first, left-first search for a free node of the wanted order.
  function automatic bit claim_block(int unsigned node, int ord, int want);
    if (ord < want || tree_st[node] == NODE_USED) return 1'b0;
    if (tree_st[node] == NODE_SPLIT) begin
      if (ord == 0) return 1'b0;
      if (claim_block(2 * node + 1, ord - 1, want)) return 1'b1;
      return claim_block(2 * node + 2, ord - 1, want);
    end
    if (ord == want) begin
      tree_st[node] = NODE_USED;
      claimed_node = node;
      return 1'b1;
    end
    n_split++;
    tree_st[node] = NODE_SPLIT;
    return claim_block(2 * node + 1, ord - 1, want);
  endfunction

  // Applies one request to the shadow tree and returns the result it should give.
  function automatic result_t predict_outcome(req_t r);
    result_t     o;
    int          sh, lv, k, d, ord;
    logic [63:0] minb, size, addr, region, ofs;
    int unsigned idx, buddy;
    sh = (shift_reg > SHIFT_CAP) ? SHIFT_CAP : shift_reg;
    lv = (levels_reg < 1) ? 1 : (levels_reg > 16) ? 16 : levels_reg;
    minb = 64'd1 << sh;
    ord = 0;
    ofs = '0;
    o = '0;
    o.status = STAT_OK;
    if (!r.opcode) begin
      size = r.request_size;
      if (size == 0) begin
        o.status = STAT_BAD_SIZE;
      end else begin
        k = 0;
        while (k < lv && (minb << k) < size) k++;
        if (k >= lv || !claim_block(0, lv - 1, k)) begin
          o.status = STAT_NO_SPACE;
          n_fail++;
        end else begin
          d = level_of(claimed_node);
          ord = lv - 1 - d;
          ofs = (64'(claimed_node) + 1 - (64'd1 << d)) << (sh + ord);
          n_alloc++;
          used_sum = 36'((64'(used_sum) + (minb << ord)) & MASK36);
        end
      end
    end else begin
      addr = r.free_offset;
      region = minb << (lv - 1);
      if (addr >= region || (addr & (minb - 1)) != 0) begin
        o.status = STAT_BAD_ADDR;
      end else begin
        idx = ((32'd1 << (lv - 1)) - 1) + 32'(addr >> sh);
        while (idx > 0 && tree_st[idx] != NODE_USED) idx = (idx - 1) / 2;
        if (tree_st[idx] != NODE_USED) begin
          o.status = STAT_BAD_ADDR;
        end else begin
          d = level_of(idx);
          ord = lv - 1 - d;
          ofs = (64'(idx) + 1 - (64'd1 << d)) << (sh + ord);
          n_free++;
          used_sum = 36'((64'(used_sum) - (minb << ord)) & MASK36);
          // Merge upward while the buddy is free.
          forever begin
            tree_st[idx] = NODE_FREE;
            if (idx == 0) break;
            buddy = idx[0] ? idx + 1 : idx - 1;
            if (tree_st[buddy] != NODE_FREE) break;
            n_merge++;
            idx = (idx - 1) / 2;
          end
        end
      end
    end
    o.block_offset = 35'(ofs & MASK35);
    o.block_order = 4'(ord);
    o.used_bytes = used_sum;
    o.alloc_count = n_alloc;
    o.free_count = n_free;
    o.fail_count = n_fail;
    o.split_count = n_split;
    o.merge_count = n_merge;
    return o;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      for (int i = 0; i < TREE_NODES; i++) tree_st[i] = NODE_FREE;
      shift_reg = SHIFT_RESET;
      levels_reg = LEVELS_RESET;
      used_sum = '0;
      {n_alloc, n_free, n_fail, n_split, n_merge} = '0;
      outcome_q.delete();
      errors = 0;
      checked = 0;
    end else begin
      // Result transfer: compare with the oldest expectation.
      if (done) begin
        if (outcome_q.size() == 0) begin
          errors++;
          $display("%0t ns: result with nothing expected, actual %p", $time, result);
        end else begin
          e = outcome_q.pop_front();
          checked++;
          check_field("status", e.status, result.status);
          check_field("block_offset", e.block_offset, result.block_offset);
          check_field("block_order", e.block_order, result.block_order);
          check_field("used_bytes", e.used_bytes, result.used_bytes);
          check_field("alloc_count", e.alloc_count, result.alloc_count);
          check_field("free_count", e.free_count, result.free_count);
          check_field("fail_count", e.fail_count, result.fail_count);
          check_field("split_count", e.split_count, result.split_count);
          check_field("merge_count", e.merge_count, result.merge_count);
        end
      end
      // Register write transfer.
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MIN_SHIFT) shift_reg = cfg_data[4:0];
        else if (cfg_index == REG_LEVELS) levels_reg = cfg_data[4:0];
      end
      // Request transfer.
      if (start && !busy) outcome_q.push_back(predict_outcome(req));
    end
  end

endmodule

### bench/tb_buddy_block_allocator.sv
`timescale 1ns / 1ps
module tb_buddy_block_allocator;
  import bba_pkg::*;

  typedef struct {
    logic [35:0] offset;
    logic [3:0]  order;
  } held_block_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  req_t        req;
  logic        done;
  result_t     result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_index;
  logic [31:0] cfg_data;
  int          errors, pending, checked;

  int          n_sent, n_done, gap_pct;
  logic        last_was_alloc;
  held_block_t held_q [$];

  buddy_block_allocator u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done),
    .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bba_result_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done),
    .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .errors(errors),
    .pending(pending), .checked(checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("[buddy_block_allocator] ERROR");
    $finish;
  end

  // Track granted blocks so that later frees hit real allocations.
  always @(posedge clk) begin
    if (rst) begin
      n_sent <= 0;
      n_done <= 0;
      last_was_alloc <= 1'b0;
    end else begin
      if (start && !busy) begin
        n_sent <= n_sent + 1;
        last_was_alloc <= !req.opcode;
      end
      if (done) begin
        n_done <= n_done + 1;
        if (last_was_alloc && result.status == STAT_OK)
          held_q.push_back('{{1'b0, result.block_offset}, result.block_order});
      end
    end
  end

  function automatic logic [35:0] rand36();
    return 36'({$urandom, $urandom});
  endfunction

  // Presents one request and returns at the edge of its transfer.
  task automatic send_request(logic op, logic [35:0] size, logic [35:0] ofs);
    @(negedge clk);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < gap_pct);
    end
    start <= 1'b1;
    req <= '{opcode: op, request_size: size, free_offset: ofs};
    do @(posedge clk); while (busy);
  endtask

  // Waits for every result, then writes both registers.
  task automatic write_regs(logic [31:0] shift_val, logic [31:0] levels_val);
    @(negedge clk);
    start <= 1'b0;
    while (n_done != n_sent || busy) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_MIN_SHIFT;
    cfg_data <= shift_val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= REG_LEVELS;
    cfg_data <= levels_val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item(int sh, int lv);
    logic [63:0] minb, blk, size;
    logic [35:0] ofs;
    held_block_t b;
    int k, pick;
    minb = 64'd1 << sh;
    if ($urandom_range(99) < 70) begin
      // Well-formed traffic: allocate fitting sizes, free held blocks.
      if (held_q.size() > 0 && $urandom_range(1)) begin
        pick = $urandom_range(held_q.size() - 1);
        b = held_q[pick];
        held_q.delete(pick);
        ofs = b.offset;
        if ($urandom_range(3) == 0 && b.order < 16)
          ofs = ofs + (36'($urandom_range((1 << b.order) - 1)) << sh);
        send_request(1'b1, rand36(), ofs);
      end else begin
        k = ($urandom_range(3) != 0) ? $urandom_range((lv > 4 ? 4 : lv) - 1)
                                     : $urandom_range(lv - 1);
        blk = minb << k;
        size = blk - (64'(rand36()) % ((blk >> 1) + 1));
        send_request(1'b0, 36'(size), rand36());
      end
    end else begin
      // Noise: raw field values, zero sizes, stray and misaligned offsets.
      case ($urandom_range(3))
        0: send_request(1'b0, rand36(), rand36());
        1: send_request(1'b0, '0, rand36());
        2: send_request(1'b1, rand36(), rand36());
        default: begin
          ofs = 36'(64'(rand36()) % (minb << lv));
          send_request(1'b1, rand36(), ofs);
        end
      endcase
    end
  endtask

  initial begin
    int shift_set [9] = '{4, 0, 31, 20, 0, 3, 7, 2, 5};
    int level_set [9] = '{16, 1, 0, 16, 4, 6, 8, 31, 10};
    int sh, lv, wait_cycles;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_MIN_SHIFT;
    cfg_data = '0;
    gap_pct = 15;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset settings: 16-byte blocks, 512 KiB region.
    send_request(1'b0, 36'd0, rand36());
    send_request(1'b0, 36'hF_FFFF_FFFF, rand36());
    send_request(1'b0, 36'd1, 36'hF_FFFF_FFFF);
    send_request(1'b0, 36'd17, rand36());
    send_request(1'b0, 36'd4096, rand36());
    send_request(1'b1, rand36(), 36'd8);
    send_request(1'b1, rand36(), 36'hF_FFFF_FFFF);
    send_request(1'b1, rand36(), 36'd524288);
    send_request(1'b1, rand36(), 36'h4_0000);
    send_request(1'b1, 36'hF_FFFF_FFFF, 36'd4176);
    send_request(1'b1, rand36(), 36'd0);
    send_request(1'b1, rand36(), 36'd32);
    send_request(1'b0, 36'd524288, 36'd0);
    send_request(1'b0, 36'd1, rand36());
    send_request(1'b1, '0, 36'd0);
    send_request(1'b0, 36'd524289, rand36());
    held_q.delete();

    // Random phases across register settings, extremes included.
    for (int p = 0; p < 9; p++) begin
      write_regs(shift_set[p], level_set[p]);
      sh = (shift_set[p] > SHIFT_CAP) ? SHIFT_CAP : shift_set[p];
      lv = (level_set[p] < 1) ? 1 : (level_set[p] > 16) ? 16 : level_set[p];
      gap_pct = (p == 4) ? 0 : 15;
      for (int i = 0; i < 170; i++) random_item(sh, lv);
    end

    @(negedge clk);
    start <= 1'b0;
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 200_000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (100) @(posedge clk);

    $display("Sent %0d requests over the reset settings and 9 register settings;", n_sent);
    $display("%0d results compared, %0d mismatches, %0d left unanswered.",
             checked, errors, pending);
    if (errors == 0 && pending == 0) begin
      $display("[buddy_block_allocator] OK");
    end else begin
      $display("[buddy_block_allocator] ERROR");
    end
    $finish;
  end

endmodule
